// ----- rtl/pil_pkg.sv -----
package pil_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 10;
  localparam int POS_W = 10;
  localparam int ST_W  = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD    = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_ROT_FWD = 2'd2,
    CMD_ROT_BWD = 2'd3
  } cmd_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cmd_t cmd;
    idx_t pos;
    val_t value;
    idx_t last_idx;
  } cell_ctl_t;

endpackage

// ----- rtl/pil_cell.sv -----
module pil_cell
  import pil_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  idx_t      idx,
  input  val_t      prev_val,
  input  val_t      next_val,
  input  val_t      head_val,
  input  val_t      tail_val,
  output val_t      val
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_INSERT: begin
        // entries at and after the insert point move back by one
        if (idx > ctl.pos) begin
          val <= prev_val;
        end else if (idx == ctl.pos) begin
          val <= ctl.value;
        end
      end
      CMD_ROT_FWD: begin
        // rotate toward the head, head wraps to the tail
        if (idx == ctl.last_idx) begin
          val <= head_val;
        end else if (idx < ctl.last_idx) begin
          val <= next_val;
        end
      end
      CMD_ROT_BWD: begin
        // rotate toward the tail, tail wraps to the head
        if (idx == '0) begin
          val <= tail_val;
        end else if (idx <= ctl.last_idx) begin
          val <= prev_val;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule

// ----- rtl/positional_insert_list_with_dump.sv -----
// positional insert list with dump
//
// input stream (s_*): one transaction asks to insert a value at a zero-based
// position. the list lives in a row of cells, one entry per cell. an accepted
// insert shifts the cells in the same cycle it is taken.
// output stream (m_*): after an insert the list is sent first to last
// (direction 0) then last to first (direction 1), 2*count transactions with
// m_tlast on the final one. a position beyond the count, or an insert into a
// full list, gives one status transaction with value zero and m_tlast set.
// timing: the accepted input moves the sequencer to S_FWD or S_RESP, which
// loads the first result into the output register once it is free, then one
// result per cycle while m_tready is high. the dump rotates the cell chain one
// step per result, so the chain keeps pace with the output register.
// one item is handled at a time: s_tready is high only when the previous
// item has loaded its final result into the output register.
// a stalled receiver freezes the dump; the output register holds its data.
// reset (rst, synchronous) empties the list and drops m_tvalid; cell
// contents are left as they were and are never read before being written.
module positional_insert_list_with_dump
  import pil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] position, [19:10] value, [23:20] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] entry_value, [15:10] zero
  output logic [2:0]  m_tuser,   // [1:0] status, [2] direction
  output logic        m_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_FWD,
    S_BWD
  } state_t;

  state_t    state;
  cnt_t      count;
  idx_t      step;
  status_t   resp_status;
  cell_ctl_t ctl;

  val_t cell_val  [DEPTH];
  val_t cell_prev [DEPTH];
  val_t cell_next [DEPTH];

  pos_t in_pos;
  val_t in_value;
  cnt_t count_m1;
  idx_t last_idx;
  val_t head_val;
  val_t tail_val;
  logic in_xact;
  logic out_free;
  logic pos_bad;
  logic list_full;

  assign in_pos    = s_tdata[POS_W-1:0];
  assign in_value  = s_tdata[POS_W +: VAL_W];
  assign count_m1  = count - cnt_t'(1);
  assign last_idx  = count_m1[IDX_W-1:0];
  assign head_val  = cell_val[0];
  assign tail_val  = cell_val[last_idx];

  assign s_tready  = (state == S_IDLE);
  assign in_xact   = s_tvalid && s_tready;
  // output register can take a new result this cycle
  assign out_free  = !m_tvalid || m_tready;
  assign pos_bad   = in_pos > POS_W'(count);
  assign list_full = (count == cnt_t'(DEPTH));

  // chain command for this cycle
  always_comb begin
    ctl.cmd      = CMD_HOLD;
    ctl.pos      = in_pos[IDX_W-1:0];
    ctl.value    = in_value;
    ctl.last_idx = last_idx;
    case (state)
      S_IDLE: begin
        if (in_xact && !pos_bad && !list_full) begin
          ctl.cmd = CMD_INSERT;
        end
      end
      S_FWD: begin
        if (out_free) begin
          ctl.cmd = CMD_ROT_FWD;
        end
      end
      S_BWD: begin
        if (out_free) begin
          ctl.cmd = CMD_ROT_BWD;
        end
      end
      default: begin
        ctl.cmd = CMD_HOLD;
      end
    endcase
  end

  // row of cells, neighbors wired up, ends tied off
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = '0;
    end else begin : g_mid_prev
      assign cell_prev[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = '0;
    end else begin : g_mid_next
      assign cell_next[i] = cell_val[i+1];
    end

    pil_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (idx_t'(i)),
      .prev_val (cell_prev[i]),
      .next_val (cell_next[i]),
      .head_val (head_val),
      .tail_val (tail_val),
      .val      (cell_val[i])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // last result of the previous item leaves the output register
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (in_xact) begin
            step <= '0;
            if (pos_bad) begin
              resp_status <= ST_INVALID;
              state       <= S_RESP;
            end else if (list_full) begin
              resp_status <= ST_FULL;
              state       <= S_RESP;
            end else begin
              count <= count + cnt_t'(1);
              state <= S_FWD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= {1'b0, resp_status};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_FWD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 16'(head_val);
            m_tuser  <= {1'b0, ST_OK};
            m_tlast  <= 1'b0;
            if (step == last_idx) begin
              step  <= '0;
              state <= S_BWD;
            end else begin
              step <= step + idx_t'(1);
            end
          end
        end
        S_BWD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 16'(tail_val);
            m_tuser  <= {1'b1, ST_OK};
            m_tlast  <= (step == last_idx);
            if (step == last_idx) begin
              step  <= '0;
              state <= S_IDLE;
            end else begin
              step <= step + idx_t'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
